// ===== rtl/edc_pkg.sv =====
// shared constants, types and helpers for the elastic disc collision datapath
`timescale 1ns / 1ps

package edc_pkg;

  localparam int FRAC_DEF  = 16;
  localparam int FRAC_MAX  = 24;
  localparam int NORM_BITS = 30;
  localparam int ROOT_W    = 32;
  localparam int OVL_W     = 9 + FRAC_MAX;
  localparam logic [32:0] VN_LIM = '1;

  // packed so that the input tdata maps onto it directly, first_pos_x lowest
  typedef struct packed {
    logic [7:0]         r2;
    logic signed [31:0] v2y;
    logic signed [31:0] v2x;
    logic signed [31:0] p2y;
    logic signed [31:0] p2x;
    logic [7:0]         r1;
    logic signed [31:0] v1y;
    logic signed [31:0] v1x;
    logic signed [31:0] p1y;
    logic signed [31:0] p1x;
  } pair_t;

  // travels beside the square root
  typedef struct packed {
    pair_t       pr;
    logic        sgnx;
    logic        sgny;
    logic        shf;
    logic        zero;
    logic [30:0] axs;
    logic [30:0] ays;
  } side_a_t;

  // travels beside the normal divider
  typedef struct packed {
    pair_t            pr;
    logic             sgnx;
    logic             sgny;
    logic             zero;
    logic [OVL_W-1:0] ovl;
  } side_b_t;

  // travels beside the speed divider
  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nyn;
    logic signed [33:0] v1t;
    logic signed [33:0] v2t;
    logic signed [31:0] q1x;
    logic signed [31:0] q1y;
    logic signed [31:0] q2x;
    logic signed [31:0] q2y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic               zero;
    logic               sg1;
    logic               sg2;
  } side_c_t;

  typedef struct packed {
    logic         skipped;
    logic [255:0] data;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// ===== rtl/edc_sqrt.sv =====
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module edc_sqrt #(
  parameter int SW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [2*edc_pkg::ROOT_W-1:0] rad,
  input  logic [SW-1:0]               side_in,
  output logic                        out_valid,
  output logic [edc_pkg::ROOT_W-1:0]  root,
  output logic [SW-1:0]               side_out
);
  import edc_pkg::*;

  localparam int RW = ROOT_W;

  typedef struct packed {
    logic [RW+3:0]   rem;
    logic [RW-1:0]   rt;
    logic [2*RW-1:0] rd;
  } sq_st_t;

  function automatic sq_st_t sq_step(input sq_st_t s);
    sq_st_t        o;
    logic [RW+3:0] sh;
    logic [RW+3:0] tr;
    sh = {s.rem[RW+1:0], s.rd[2*RW-1 -: 2]};
    tr = {2'b00, s.rt, 2'b01};
    if (sh >= tr) begin
      o.rem = sh - tr;
      o.rt  = {s.rt[RW-2:0], 1'b1};
    end else begin
      o.rem = sh;
      o.rt  = {s.rt[RW-2:0], 1'b0};
    end
    o.rd = {s.rd[2*RW-3:0], 2'b00};
    return o;
  endfunction

  sq_st_t        st_q [RW];
  sq_st_t        st_d [RW];
  logic [SW-1:0] side_q [RW];
  logic [RW-1:0] vld;

  always_comb begin
    sq_st_t init;
    init.rem = '0;
    init.rt  = '0;
    init.rd  = rad;
    st_d[0] = sq_step(init);
    for (int k = 1; k < RW; k++) begin
      st_d[k] = sq_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RW-2:0], in_valid};
    end
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 0; k < RW; k++) begin
        st_q[k] <= st_d[k];
      end
      for (int k = 1; k < RW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = st_q[RW-1].rt;
  assign side_out  = side_q[RW-1];

endmodule

// ===== rtl/edc_div.sv =====
// pipelined two-lane restoring divider with a shared divisor
`timescale 1ns / 1ps

module edc_div #(
  parameter int NW = 61,
  parameter int DW = 32,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num_a,
  input  logic [NW-1:0] num_b,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo_a,
  output logic [QW-1:0] quo_b,
  output logic [SW-1:0] side_out
);
  import edc_pkg::*;

  typedef struct packed {
    logic [DW-1:0] ra;
    logic [QW-1:0] wa;
    logic [DW-1:0] rb;
    logic [QW-1:0] wb;
    logic [DW-1:0] d;
  } dv_st_t;

  function automatic dv_st_t dv_step(input dv_st_t s);
    dv_st_t      o;
    logic [DW:0] sha;
    logic [DW:0] shb;
    logic [DW:0] dd;
    logic [DW:0] dfa;
    logic [DW:0] dfb;
    dd  = {1'b0, s.d};
    sha = {s.ra, s.wa[QW-1]};
    shb = {s.rb, s.wb[QW-1]};
    dfa = sha - dd;
    dfb = shb - dd;
    o.d  = s.d;
    o.ra = (sha >= dd) ? dfa[DW-1:0] : sha[DW-1:0];
    o.rb = (shb >= dd) ? dfb[DW-1:0] : shb[DW-1:0];
    o.wa = {s.wa[QW-2:0], sha >= dd};
    o.wb = {s.wb[QW-2:0], shb >= dd};
    return o;
  endfunction

  dv_st_t        st_q [QW];
  dv_st_t        st_d [QW];
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] vld;

  // the quotient is known to fit, so the high dividend bits start below the divisor
  always_comb begin
    dv_st_t init;
    init.ra = DW'(num_a[NW-1:QW]);
    init.rb = DW'(num_b[NW-1:QW]);
    init.wa = num_a[QW-1:0];
    init.wb = num_b[QW-1:0];
    init.d  = den;
    st_d[0] = dv_step(init);
    for (int k = 1; k < QW; k++) begin
      st_d[k] = dv_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_valid};
    end
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 0; k < QW; k++) begin
        st_q[k] <= st_d[k];
      end
      for (int k = 1; k < QW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo_a     = st_q[QW-1].wa;
  assign quo_b     = st_q[QW-1].wb;
  assign side_out  = side_q[QW-1];

endmodule

// ===== rtl/elastic_disc_collision.sv =====
// top level: elastic collision of two discs, fully pipelined
`timescale 1ns / 1ps
// throughput: one word per cycle while the output buffer is not full; the square root (32 stages) and the two
//   dividers (31 and 35 stages) are unrolled one bit per stage
// a two-word output buffer lets input flow while one result waits
// reset (rst, synchronous) empties all stages and the output buffer

module elastic_disc_collision #(
  parameter int FRAC_BITS = edc_pkg::FRAC_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
  // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius
  input  logic [271:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
  // new_first_pos_x, new_first_pos_y, new_second_pos_x, new_second_pos_y
  output logic [255:0] m_tdata,
  // skipped
  output logic         m_tuser
);
  import edc_pkg::*;

  // global advance: the whole pipe moves unless the output buffer is full
  logic [1:0] cnt;
  logic       en;
  logic       push;
  logic       pop;

  assign en       = (cnt != 2'd2);
  assign s_tready = en;

  logic v1, v2, v3, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14, v15;

  // stage 1: input word
  pair_t s1_pr;

  // stage 2: centre difference, magnitude, prescale
  logic signed [32:0] dx, dy, adx, ady;
  pair_t       s2_pr;
  logic        s2_sgnx, s2_sgny, s2_shf, s2_zero;
  logic [30:0] s2_axs, s2_ays;

  assign dx  = 33'(s1_pr.p2x) - 33'(s1_pr.p1x);
  assign dy  = 33'(s1_pr.p2y) - 33'(s1_pr.p1y);
  assign adx = dx[32] ? -dx : dx;
  assign ady = dy[32] ? -dy : dy;

  // stage 3: squares
  pair_t       s3_pr;
  logic        s3_sgnx, s3_sgny, s3_shf, s3_zero;
  logic [30:0] s3_axs, s3_ays;
  logic [61:0] s3_sqx, s3_sqy;

  side_a_t     sa_in, sa_out;
  logic [31:0] sq_root;
  logic        sq_v;

  assign sa_in = '{pr: s3_pr, sgnx: s3_sgnx, sgny: s3_sgny, shf: s3_shf,
                   zero: s3_zero, axs: s3_axs, ays: s3_ays};

  edc_sqrt #(.SW($bits(side_a_t))) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .rad(64'(s3_sqx) + 64'(s3_sqy)), .side_in(sa_in),
    .out_valid(sq_v), .root(sq_root), .side_out(sa_out)
  );

  // magnitude and overlap right after the root
  logic [31:0]        m_fix;
  logic [32:0]        mag;
  logic [35:0]        rsum_sh;
  logic signed [35:0] ov;
  side_b_t            sb_in, sb_out;
  logic [30:0]        d1_qx, d1_qy;
  logic               d1_v;

  assign m_fix   = (sq_root == '0) ? 32'd1 : sq_root;
  assign mag     = sa_out.shf ? {m_fix, 1'b0} : {1'b0, m_fix};
  assign rsum_sh = 36'(9'(sa_out.pr.r1) + 9'(sa_out.pr.r2)) << FRAC_BITS;
  assign ov      = $signed(rsum_sh - 36'(mag));
  assign sb_in   = '{pr: sa_out.pr, sgnx: sa_out.sgnx, sgny: sa_out.sgny,
                     zero: sa_out.zero,
                     ovl: (ov > 36'sd0) ? ov[OVL_W-1:0] : '0};

  // unit normal magnitudes with 30 fraction bits
  edc_div #(.NW(31 + NORM_BITS), .DW(32), .QW(31), .SW($bits(side_b_t))) u_div_n (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq_v),
    .num_a({sa_out.axs, {NORM_BITS{1'b0}}}), .num_b({sa_out.ays, {NORM_BITS{1'b0}}}),
    .den(m_fix), .side_in(sb_in),
    .out_valid(d1_v), .quo_a(d1_qx), .quo_b(d1_qy), .side_out(sb_out)
  );

  // stage 5: signed normal, radius squares
  pair_t              s5_pr;
  logic               s5_zero;
  logic [OVL_W-1:0]   s5_ovl;
  logic signed [31:0] s5_nx, s5_ny, s5_nyn;
  logic [15:0]        s5_r1sq, s5_r2sq;

  // stage 6: projection products, push products, cubes
  pair_t              s6_pr;
  logic               s6_zero;
  logic signed [31:0] s6_nx, s6_ny, s6_nyn;
  logic signed [63:0] s6_pn1a, s6_pn1b, s6_pt1a, s6_pt1b;
  logic signed [63:0] s6_pn2a, s6_pn2b, s6_pt2a, s6_pt2b;
  logic signed [65:0] s6_pcx, s6_pcy;
  logic [23:0]        s6_r1c, s6_r2c;

  // stage 7: normal and tangent speeds, push, masses
  pair_t              s7_pr;
  logic               s7_zero;
  logic signed [31:0] s7_nx, s7_ny, s7_nyn;
  logic signed [33:0] s7_v1n, s7_v1t, s7_v2n, s7_v2t;
  logic signed [34:0] s7_cx, s7_cy;
  logic [23:0]        s7_m1, s7_m2;

  // stage 8: mass terms, pushed positions
  pair_t              s8_pr;
  logic               s8_zero;
  logic signed [31:0] s8_nx, s8_ny, s8_nyn;
  logic signed [33:0] s8_v1n, s8_v1t, s8_v2n, s8_v2t;
  logic signed [24:0] s8_dm;
  logic [24:0]        s8_tm1, s8_tm2, s8_sum;
  logic signed [31:0] s8_q1x, s8_q1y, s8_q2x, s8_q2y;

  // stage 9: momentum products
  pair_t              s9_pr;
  logic               s9_zero;
  logic signed [31:0] s9_nx, s9_ny, s9_nyn;
  logic signed [33:0] s9_v1t, s9_v2t;
  logic signed [59:0] s9_a, s9_b, s9_c, s9_d;
  logic [24:0]        s9_sum;
  logic signed [31:0] s9_q1x, s9_q1y, s9_q2x, s9_q2y;

  // stage 10: numerators
  pair_t              s10_pr;
  logic               s10_zero;
  logic signed [31:0] s10_nx, s10_ny, s10_nyn;
  logic signed [33:0] s10_v1t, s10_v2t;
  logic signed [60:0] s10_num1, s10_num2;
  logic [24:0]        s10_sum;
  logic signed [31:0] s10_q1x, s10_q1y, s10_q2x, s10_q2y;

  // stage 11: sign and magnitude for the divider
  side_c_t     s11_sc;
  logic [57:0] s11_mag1, s11_mag2;
  logic [24:0] s11_sum;

  side_c_t     sc_out;
  logic [34:0] d2_q1, d2_q2;
  logic        d2_v;

  edc_div #(.NW(58), .DW(25), .QW(35), .SW($bits(side_c_t))) u_div_v (
    .clk(clk), .rst(rst), .en(en), .in_valid(v11),
    .num_a(s11_mag1), .num_b(s11_mag2), .den(s11_sum), .side_in(s11_sc),
    .out_valid(d2_v), .quo_a(d2_q1), .quo_b(d2_q2), .side_out(sc_out)
  );

  // stage 12: clamped new normal speeds, truncated toward zero
  logic [32:0]        cl1, cl2;
  side_c_t            s12_sc;
  logic signed [33:0] s12_v1np, s12_v2np;

  assign cl1 = (d2_q1 > 35'(VN_LIM)) ? VN_LIM : d2_q1[32:0];
  assign cl2 = (d2_q2 > 35'(VN_LIM)) ? VN_LIM : d2_q2[32:0];

  // stage 13: recombination products
  side_c_t            s13_sc;
  logic signed [65:0] s13_p1xa, s13_p1xb, s13_p1ya, s13_p1yb;
  logic signed [65:0] s13_p2xa, s13_p2xb, s13_p2ya, s13_p2yb;

  // stage 14: recombined velocities
  side_c_t            s14_sc;
  logic signed [36:0] s14_n1x, s14_n1y, s14_n2x, s14_n2y;

  // stage 15: saturate, pass through on coincident centres
  res_t s15_res;
  logic [127:0] vel_out;

  assign vel_out = s14_sc.zero ?
      {s14_sc.v2y, s14_sc.v2x, s14_sc.v1y, s14_sc.v1x} :
      {sat32(40'(s14_n2y)), sat32(40'(s14_n2x)),
       sat32(40'(s14_n1y)), sat32(40'(s14_n1x))};

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14, v15} <= '0;
    end else if (en) begin
      v1  <= s_tvalid;
      v2  <= v1;
      v3  <= v2;
      v5  <= d1_v;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
      v12 <= d2_v;
      v13 <= v12;
      v14 <= v13;
      v15 <= v14;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pr <= pair_t'(s_tdata);

      s2_pr   <= s1_pr;
      s2_sgnx <= dx[32];
      s2_sgny <= dy[32];
      s2_shf  <= adx[31] | ady[31];
      s2_axs  <= (adx[31] | ady[31]) ? adx[31:1] : adx[30:0];
      s2_ays  <= (adx[31] | ady[31]) ? ady[31:1] : ady[30:0];
      s2_zero <= (dx == '0) && (dy == '0);

      s3_pr   <= s2_pr;
      s3_sgnx <= s2_sgnx;
      s3_sgny <= s2_sgny;
      s3_shf  <= s2_shf;
      s3_zero <= s2_zero;
      s3_axs  <= s2_axs;
      s3_ays  <= s2_ays;
      s3_sqx  <= 62'(s2_axs) * 62'(s2_axs);
      s3_sqy  <= 62'(s2_ays) * 62'(s2_ays);

      s5_pr   <= sb_out.pr;
      s5_zero <= sb_out.zero;
      s5_ovl  <= sb_out.ovl;
      s5_nx   <= sb_out.sgnx ? -$signed(32'(d1_qx)) : $signed(32'(d1_qx));
      s5_ny   <= sb_out.sgny ? -$signed(32'(d1_qy)) : $signed(32'(d1_qy));
      s5_nyn  <= sb_out.sgny ? $signed(32'(d1_qy)) : -$signed(32'(d1_qy));
      s5_r1sq <= 16'(sb_out.pr.r1) * 16'(sb_out.pr.r1);
      s5_r2sq <= 16'(sb_out.pr.r2) * 16'(sb_out.pr.r2);

      s6_pr   <= s5_pr;
      s6_zero <= s5_zero;
      s6_nx   <= s5_nx;
      s6_ny   <= s5_ny;
      s6_nyn  <= s5_nyn;
      s6_pn1a <= s5_nx * $signed(s5_pr.v1x);
      s6_pn1b <= s5_ny * $signed(s5_pr.v1y);
      s6_pt1a <= s5_nyn * $signed(s5_pr.v1x);
      s6_pt1b <= s5_nx * $signed(s5_pr.v1y);
      s6_pn2a <= s5_nx * $signed(s5_pr.v2x);
      s6_pn2b <= s5_ny * $signed(s5_pr.v2y);
      s6_pt2a <= s5_nyn * $signed(s5_pr.v2x);
      s6_pt2b <= s5_nx * $signed(s5_pr.v2y);
      s6_pcx  <= s5_nx * $signed({1'b0, s5_ovl});
      s6_pcy  <= s5_ny * $signed({1'b0, s5_ovl});
      s6_r1c  <= 24'(s5_r1sq) * 24'(s5_pr.r1);
      s6_r2c  <= 24'(s5_r2sq) * 24'(s5_pr.r2);

      // halve each product, add, then drop the remaining fraction bits
      s7_pr   <= s6_pr;
      s7_zero <= s6_zero;
      s7_nx   <= s6_nx;
      s7_ny   <= s6_ny;
      s7_nyn  <= s6_nyn;
      s7_v1n  <= 34'(((s6_pn1a >>> 1) + (s6_pn1b >>> 1)) >>> (NORM_BITS - 1));
      s7_v1t  <= 34'(((s6_pt1a >>> 1) + (s6_pt1b >>> 1)) >>> (NORM_BITS - 1));
      s7_v2n  <= 34'(((s6_pn2a >>> 1) + (s6_pn2b >>> 1)) >>> (NORM_BITS - 1));
      s7_v2t  <= 34'(((s6_pt2a >>> 1) + (s6_pt2b >>> 1)) >>> (NORM_BITS - 1));
      s7_cx   <= 35'(s6_pcx >>> (NORM_BITS + 1));
      s7_cy   <= 35'(s6_pcy >>> (NORM_BITS + 1));
      // two massless discs behave as equal unit masses
      s7_m1   <= (s6_pr.r1 == '0 && s6_pr.r2 == '0) ? 24'd1 : s6_r1c;
      s7_m2   <= (s6_pr.r1 == '0 && s6_pr.r2 == '0) ? 24'd1 : s6_r2c;

      s8_pr   <= s7_pr;
      s8_zero <= s7_zero;
      s8_nx   <= s7_nx;
      s8_ny   <= s7_ny;
      s8_nyn  <= s7_nyn;
      s8_v1n  <= s7_v1n;
      s8_v1t  <= s7_v1t;
      s8_v2n  <= s7_v2n;
      s8_v2t  <= s7_v2t;
      s8_dm   <= $signed({1'b0, s7_m1}) - $signed({1'b0, s7_m2});
      s8_tm1  <= {s7_m1, 1'b0};
      s8_tm2  <= {s7_m2, 1'b0};
      s8_sum  <= 25'(s7_m1) + 25'(s7_m2);
      s8_q1x  <= sat32(40'($signed(s7_pr.p1x)) - 40'(s7_cx));
      s8_q1y  <= sat32(40'($signed(s7_pr.p1y)) - 40'(s7_cy));
      s8_q2x  <= sat32(40'($signed(s7_pr.p2x)) + 40'(s7_cx));
      s8_q2y  <= sat32(40'($signed(s7_pr.p2y)) + 40'(s7_cy));

      s9_pr   <= s8_pr;
      s9_zero <= s8_zero;
      s9_nx   <= s8_nx;
      s9_ny   <= s8_ny;
      s9_nyn  <= s8_nyn;
      s9_v1t  <= s8_v1t;
      s9_v2t  <= s8_v2t;
      s9_a    <= s8_v1n * s8_dm;
      s9_b    <= s8_v2n * s8_dm;
      s9_c    <= s8_v2n * $signed({1'b0, s8_tm2});
      s9_d    <= s8_v1n * $signed({1'b0, s8_tm1});
      s9_sum  <= s8_sum;
      s9_q1x  <= s8_q1x;
      s9_q1y  <= s8_q1y;
      s9_q2x  <= s8_q2x;
      s9_q2y  <= s8_q2y;

      s10_pr   <= s9_pr;
      s10_zero <= s9_zero;
      s10_nx   <= s9_nx;
      s10_ny   <= s9_ny;
      s10_nyn  <= s9_nyn;
      s10_v1t  <= s9_v1t;
      s10_v2t  <= s9_v2t;
      s10_num1 <= 61'(s9_a) + 61'(s9_c);
      s10_num2 <= 61'(s9_d) - 61'(s9_b);
      s10_sum  <= s9_sum;
      s10_q1x  <= s9_q1x;
      s10_q1y  <= s9_q1y;
      s10_q2x  <= s9_q2x;
      s10_q2y  <= s9_q2y;

      s11_mag1 <= s10_num1[60] ? 58'(-s10_num1) : s10_num1[57:0];
      s11_mag2 <= s10_num2[60] ? 58'(-s10_num2) : s10_num2[57:0];
      s11_sum  <= s10_sum;
      s11_sc   <= '{nx: s10_nx, ny: s10_ny, nyn: s10_nyn, v1t: s10_v1t, v2t: s10_v2t,
                    q1x: s10_q1x, q1y: s10_q1y, q2x: s10_q2x, q2y: s10_q2y,
                    v1x: s10_pr.v1x, v1y: s10_pr.v1y,
                    v2x: s10_pr.v2x, v2y: s10_pr.v2y,
                    zero: s10_zero, sg1: s10_num1[60], sg2: s10_num2[60]};

      s12_sc   <= sc_out;
      s12_v1np <= sc_out.sg1 ? -$signed({1'b0, cl1}) : $signed({1'b0, cl1});
      s12_v2np <= sc_out.sg2 ? -$signed({1'b0, cl2}) : $signed({1'b0, cl2});

      s13_sc   <= s12_sc;
      s13_p1xa <= $signed(s12_sc.nx) * s12_v1np;
      s13_p1xb <= $signed(s12_sc.nyn) * $signed(s12_sc.v1t);
      s13_p1ya <= $signed(s12_sc.ny) * s12_v1np;
      s13_p1yb <= $signed(s12_sc.nx) * $signed(s12_sc.v1t);
      s13_p2xa <= $signed(s12_sc.nx) * s12_v2np;
      s13_p2xb <= $signed(s12_sc.nyn) * $signed(s12_sc.v2t);
      s13_p2ya <= $signed(s12_sc.ny) * s12_v2np;
      s13_p2yb <= $signed(s12_sc.nx) * $signed(s12_sc.v2t);

      s14_sc  <= s13_sc;
      s14_n1x <= 37'(((s13_p1xa >>> 1) + (s13_p1xb >>> 1)) >>> (NORM_BITS - 1));
      s14_n1y <= 37'(((s13_p1ya >>> 1) + (s13_p1yb >>> 1)) >>> (NORM_BITS - 1));
      s14_n2x <= 37'(((s13_p2xa >>> 1) + (s13_p2xb >>> 1)) >>> (NORM_BITS - 1));
      s14_n2y <= 37'(((s13_p2ya >>> 1) + (s13_p2yb >>> 1)) >>> (NORM_BITS - 1));

      // positions need no override: the normal is zero when centres coincide
      s15_res.skipped <= s14_sc.zero;
      s15_res.data    <= {s14_sc.q2y, s14_sc.q2x, s14_sc.q1y, s14_sc.q1x, vel_out};
    end
  end

  // two-word output buffer, head in slot0
  res_t slot0, slot1;

  assign push = en && v15;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd1) begin
        slot0 <= s15_res;
      end else begin
        slot0 <= slot1;
        slot1 <= s15_res;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        slot0 <= s15_res;
      end else begin
        slot1 <= s15_res;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = slot0.data;
  assign m_tuser  = slot0.skipped;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");
  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
      !$past(rst) |-> cnt == $past(cnt) + {1'b0, $past(push)} - {1'b0, $past(pop)})
    else $error("output buffer count lost track of words");
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
      (!en && v15) |=> v15)
    else $error("stalled result dropped from last stage");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
      (cnt == 2'd2) |-> !push)
    else $error("result pushed into a full output buffer");
`endif

endmodule
